// File: hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg : shared definitions for the 3x3 box blur
// Widths, the line-store depth, the reciprocal used for the divide by nine,
// the step kinds and the result-queue entry type.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	localparam int SAMPLE_W  = 8;
	localparam int FW_W      = 12;
	localparam int FH_W      = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd512;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd512;

	// Vertical sum of three samples and full 3x3 sum.
	localparam int COLSUM_W = 10;
	localparam int SUM_W    = 12;

	// floor(x / 9) = (x * 3641) >> 15, exact for x below 32768.
	localparam int          DIV_SHIFT = 15;
	localparam logic [11:0] DIV_RECIP = 12'd3641;
	localparam int          PROD_W    = SUM_W + 12;

	// Result queue.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_STORE,   // first row of a frame: samples are only stored
		KIND_PIXEL,   // normal pixel in a later row
		KIND_FLUSH    // drain step for the bottom row
	} step_kind_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             row_end;
		logic             frame_end;
	} result_t;

endpackage

// File: hdl/box_blur_3x3_u8_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_u8_top : streaming 3x3 box blur of an 8-bit image plane
// Two line stores in block memory, a three-column window and a small result
// queue; replicated edges and an exact divide by nine.
// ----------------------------------------------------------------------------
// The block takes one 8-bit sample per clock in raster order and returns
// floor(sum of the 3x3 neighbourhood / 9), with neighbours outside the frame
// replaced by the nearest edge sample. Output row y appears while input row
// y+1 arrives, one column behind; the last sample of a row also yields the
// last output of the previous row, so that transaction gives two results.
// After the last sample of a frame the user sends frame_width drain
// transactions, which flush the bottom row. A drain transaction outside a
// flush is swallowed; a pixel transaction during a flush is treated as a
// drain. The input side sustains one transaction per clock: each one reads
// both line stores at its column on the cycle it is accepted and writes
// them back on the next, so the single-port-per-direction memories set that
// rate. Results sit in an eight-entry queue that is emptied one per clock;
// in_stall rises only when the queue could not absorb two results each for
// the item in stage 1 and a new one, which in a free-running stream happens
// only if out_stall is held. The line stores are not cleared after reset:
// the first row of every frame writes them before they are read. frame_width
// and frame_height are written through wr_en, wr_index and wr_data and should
// only change while the block is idle.
module box_blur_3x3_u8_top (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           wr_en,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bb3_pkg::CFG_W-1:0]      wr_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bb3_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           drain,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bb3_pkg::SAMPLE_W-1:0]   blurred,
	output logic                           row_end,
	output logic                           frame_end
);
	import bb3_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_WIDTH:  frame_width_q  <= wr_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= wr_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// A width of zero acts as one, and anything above the line-store depth
	// is clipped to it. A height of zero acts as one.
	logic [COL_W:0]  active_width;
	logic [FH_W-1:0] active_height;

	always_comb begin
		if (frame_width_q == '0) begin
			active_width = (COL_W+1)'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			active_width = (COL_W+1)'(MAX_WIDTH);
		end else begin
			active_width = (COL_W+1)'(frame_width_q);
		end
		active_height = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end

	// ------------------------------------------------------------------
	// Position tracking, done on the cycle a transaction is accepted.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [FH_W-1:0]  row_q;
	logic             draining_q;

	logic       in_accept;
	logic       take;
	logic       last_col;
	logic       last_row;
	step_kind_t kind;

	assign in_accept = in_valid && !in_stall;
	// A drain outside a flush changes nothing and yields nothing.
	assign take      = in_accept && (draining_q || !drain);
	assign last_col  = ({1'b0, col_q} + (COL_W+1)'(1)) >= active_width;
	assign last_row  = ({1'b0, row_q} + (FH_W+1)'(1)) >= {1'b0, active_height};

	always_comb begin
		if (draining_q) begin
			kind = KIND_FLUSH;
		end else if (row_q == '0) begin
			kind = KIND_STORE;
		end else begin
			kind = KIND_PIXEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (take) begin
			if (!last_col) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				priority if (draining_q) begin
					draining_q <= 1'b0;
					row_q      <= '0;
				end else if (last_row) begin
					draining_q <= 1'b1;
				end else begin
					row_q <= row_q + FH_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the line stores are read at the accepted column; in the next
	// cycle the data is here and the column is written back.
	// ------------------------------------------------------------------
	logic                s1_valid;
	step_kind_t          s1_kind;
	logic [COL_W-1:0]    s1_col;
	logic                s1_last;
	logic [SAMPLE_W-1:0] s1_sample;
	logic                s1_fwd;
	logic [SAMPLE_W-1:0] fwd_older_s1;
	logic [SAMPLE_W-1:0] fwd_newer_s1;
	logic [SAMPLE_W-1:0] rd_older_s1;
	logic [SAMPLE_W-1:0] rd_newer_s1;

	logic [SAMPLE_W-1:0] older_mem [MAX_WIDTH];
	logic [SAMPLE_W-1:0] newer_mem [MAX_WIDTH];

	logic                mem_we;
	logic [SAMPLE_W-1:0] older_wdata;
	logic [SAMPLE_W-1:0] newer_wdata;
	logic [SAMPLE_W-1:0] older_cur;
	logic [SAMPLE_W-1:0] newer_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_kind      <= kind;
			s1_col       <= col_q;
			s1_last      <= last_col;
			s1_sample    <= sample;
			// The read happens at the same edge as the write of the item
			// ahead of it; on the same column the memory gives stale data.
			s1_fwd       <= mem_we && (s1_col == col_q);
			fwd_older_s1 <= older_wdata;
			fwd_newer_s1 <= newer_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd_older_s1 <= older_mem[col_q];
			rd_newer_s1 <= newer_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			older_mem[s1_col] <= older_wdata;
			newer_mem[s1_col] <= newer_wdata;
		end
	end

	assign older_cur = s1_fwd ? fwd_older_s1 : rd_older_s1;
	assign newer_cur = s1_fwd ? fwd_newer_s1 : rd_newer_s1;
	assign mem_we    = s1_valid && (s1_kind != KIND_FLUSH);

	always_comb begin
		unique case (s1_kind)
			KIND_STORE: begin
				older_wdata = s1_sample;
				newer_wdata = s1_sample;
			end
			default: begin
				older_wdata = newer_cur;
				newer_wdata = s1_sample;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Column sums and the horizontal window.
	// ------------------------------------------------------------------
	logic [COLSUM_W-1:0] colsum;
	logic [COLSUM_W-1:0] win_q [3];
	logic                win_upd;
	logic [SUM_W-1:0]    mid_sum;
	logic [SUM_W-1:0]    edge_sum;

	always_comb begin
		if (s1_kind == KIND_FLUSH) begin
			// Bottom row stands in for its own lower neighbour.
			colsum = COLSUM_W'(older_cur) + (COLSUM_W'(newer_cur) << 1);
		end else begin
			colsum = COLSUM_W'(older_cur) + COLSUM_W'(newer_cur) + COLSUM_W'(s1_sample);
		end
	end

	assign win_upd = s1_valid && (s1_kind != KIND_STORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (win_upd) begin
			if (s1_col == '0) begin
				win_q[0] <= colsum;
				win_q[1] <= colsum;
				win_q[2] <= colsum;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= colsum;
			end
		end
	end

	// Interior result: the window after the shift. Right-edge result: the
	// new middle column plus the right column taken twice.
	assign mid_sum = SUM_W'(win_q[1]) + SUM_W'(win_q[2]) + SUM_W'(colsum);

	always_comb begin
		if (s1_col == '0) begin
			edge_sum = SUM_W'(colsum) + (SUM_W'(colsum) << 1);
		end else begin
			edge_sum = SUM_W'(win_q[2]) + (SUM_W'(colsum) << 1);
		end
	end

	// ------------------------------------------------------------------
	// Result queue: up to two pushes and one pop a cycle.
	// ------------------------------------------------------------------
	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	logic    push_mid;
	logic    push_edge;
	logic    pop;
	result_t res_mid;
	result_t res_edge;
	logic [FIFO_CNT_W-1:0] n_push;

	assign push_mid  = win_upd && (s1_col != '0);
	assign push_edge = win_upd && s1_last;
	assign n_push    = FIFO_CNT_W'(push_mid) + FIFO_CNT_W'(push_edge);
	assign pop       = out_valid && !out_stall;

	assign res_mid  = '{sum: mid_sum, row_end: 1'b0, frame_end: 1'b0};
	assign res_edge = '{sum: edge_sum, row_end: 1'b1,
		frame_end: (s1_kind == KIND_FLUSH)};

	always_ff @(posedge clk) begin
		if (push_mid) begin
			fifo_q[wr_ptr_q] <= res_mid;
			if (push_edge) begin
				fifo_q[wr_ptr_q + FIFO_PTR_W'(1)] <= res_edge;
			end
		end else if (push_edge) begin
			fifo_q[wr_ptr_q] <= res_edge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

	// Room must remain for the item in stage 1 and for the one being taken,
	// two results each, even if nothing is popped meanwhile.
	assign in_stall = (32'(count_q) + (s1_valid ? 32'd2 : 32'd0) + 32'd2) > 32'(FIFO_DEPTH);

	// ------------------------------------------------------------------
	// Output: divide by nine through the reciprocal on the queue head.
	// ------------------------------------------------------------------
	result_t           head;
	logic [PROD_W-1:0] prod;

	assign head      = fifo_q[rd_ptr_q];
	assign prod      = PROD_W'(head.sum) * PROD_W'(DIV_RECIP);
	assign out_valid = (count_q != '0);
	assign blurred   = prod[DIV_SHIFT + SAMPLE_W - 1 : DIV_SHIFT];
	assign row_end   = head.row_end;
	assign frame_end = head.frame_end;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(FIFO_DEPTH))
		else $error("result queue over capacity");

	a_s1_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> 32'(count_q) + 32'd2 <= 32'(FIFO_DEPTH))
		else $error("stage 1 item without room for its results");

	a_flush_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && (s1_kind == KIND_FLUSH)) |-> $past(draining_q))
		else $error("flush step entered outside a flush");

	a_frame_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> row_end)
		else $error("frame end without row end");

endmodule
